// ----- hdl/pcmmix_pkg.sv -----
// Shared types and constants for the multichannel PCM mixer.
package pcmmix_pkg;

	// Request kinds carried in the input item's tuser field
	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_PLAY = 2'd1,
		REQ_STOP = 2'd2,
		REQ_MIX  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;   // latch incoming item, clear per-item accumulators
		logic store_we;  // write the load byte into the sample store
		logic step;      // process the voice under the scan index
		logic publish;   // move the result into the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		req_t op;        // kind of the item in progress
		logic last;      // scan index is on the last voice in use
		logic free;      // voice under the scan index has no bytes left
		logic out_busy;  // output register full and not taken this cycle
	} sts_t;

	localparam logic [3:0] CFG_NCH_RESET = 4'd6;
	localparam logic [3:0] CFG_NCH_MIN   = 4'd2;
	localparam int         SAMPLE_MID    = 128;
	localparam int         SAMPLE_MAX    = 255;
	localparam int         DATA_W        = 8;

endpackage

// ----- hdl/pcmmix_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pcmmix_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/pcmmix_ctrl.sv -----
// Sequencer for the PCM mixer: one item at a time, one voice per scan cycle.
module pcmmix_ctrl
	import pcmmix_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  req_t req_in,
	output logic s_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = (req_in == REQ_LOAD) ? ST_LOAD : ST_SCAN;
				end
			end
			ST_LOAD: begin
				cmd.store_we = 1'b1;
				state_d      = ST_DONE;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				unique case (sts.op)
					REQ_PLAY: if (sts.free || sts.last) state_d = ST_DONE;
					REQ_STOP: if (sts.last) state_d = ST_DONE;
					REQ_MIX:  if (sts.last) state_d = ST_DRAIN;
					REQ_LOAD: state_d = ST_DONE;
				endcase
			end
			// last store read lands in the accumulator here
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_drain_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_DONE)
		else $error("drain cycle not followed by result cycle");

	a_load_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_we |=> !cmd.store_we)
		else $error("store write held for more than one cycle");

	a_publish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> state_q == ST_IDLE)
		else $error("publish did not return to idle");
`endif

endmodule

// ----- hdl/pcmmix_dp.sv -----
// Datapath: voice registers, sample store, mix accumulator and result register.
module pcmmix_dp
	import pcmmix_pkg::*;
#(
	parameter int MAX_VOICES      = 8,
	parameter int STORE_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req_in,
	input  logic [63:0] s_tdata,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int VIDX_W = $clog2(MAX_VOICES);
	localparam int CNT_W  = $clog2(MAX_VOICES + 1);
	localparam int ACC_W  = $clog2(MAX_VOICES * SAMPLE_MID + SAMPLE_MAX + 1) + 1;
	localparam int ADDR_W = STORE_ADDR_BITS;

	logic [3:0]        nch_q;
	req_t              op_q;
	logic [7:0]        id_q;
	logic [15:0]       start_q;
	logic [15:0]       len_q;
	logic [15:0]       laddr_q;
	logic [7:0]        lbyte_q;
	logic [VIDX_W-1:0] vidx_q;
	logic [VIDX_W-1:0] last_idx_q, last_idx_d;

	logic [ADDR_W-1:0] pos_q [MAX_VOICES];
	logic [15:0]       rem_q [MAX_VOICES];
	logic [7:0]        snd_q [MAX_VOICES];

	logic                    act_s1;
	logic signed [ACC_W-1:0] acc_q, samp_sx;
	logic [CNT_W-1:0]        active_q, stopped_q;
	logic                    accepted_q;
	logic [VIDX_W-1:0]       chan_q;
	logic [7:0]              clip;
	logic [DATA_W-1:0]       rd_data;
	logic                    free;
	logic                    out_valid_q;
	logic [23:0]             out_data_q;

	assign free = (rem_q[vidx_q] == 16'd0);

	always_comb begin
		sts.op       = op_q;
		sts.last     = (vidx_q == last_idx_q);
		sts.free     = free;
		sts.out_busy = out_valid_q && !m_tready;
	end

	// clamp the configured voice count to 2..MAX_VOICES, as a last index
	always_comb begin
		if (nch_q < CFG_NCH_MIN) begin
			last_idx_d = VIDX_W'(1);
		end else if (int'(nch_q) > MAX_VOICES) begin
			last_idx_d = VIDX_W'(MAX_VOICES - 1);
		end else begin
			last_idx_d = VIDX_W'(nch_q - 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q <= CFG_NCH_RESET;
		end else if (cfg_we) begin
			nch_q <= cfg_data;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q    <= s_tdata[7:0];
			start_q <= s_tdata[23:8];
			len_q   <= s_tdata[39:24];
			laddr_q <= s_tdata[55:40];
			lbyte_q <= s_tdata[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= REQ_LOAD;
			vidx_q     <= '0;
			last_idx_q <= VIDX_W'(1);
		end else if (cmd.capture) begin
			op_q       <= req_in;
			vidx_q     <= '0;
			last_idx_q <= last_idx_d;
		end else if (cmd.step && !sts.last) begin
			vidx_q <= vidx_q + VIDX_W'(1);
		end
	end

	// voice state, one voice touched per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VOICES; i++) begin
				pos_q[i] <= '0;
				rem_q[i] <= '0;
				snd_q[i] <= '0;
			end
		end else if (cmd.step) begin
			unique case (op_q)
				REQ_PLAY: begin
					if (free) begin
						pos_q[vidx_q] <= ADDR_W'(start_q);
						rem_q[vidx_q] <= len_q;
						snd_q[vidx_q] <= id_q;
					end
				end
				REQ_STOP: begin
					if (snd_q[vidx_q] == id_q) begin
						pos_q[vidx_q] <= '0;
						rem_q[vidx_q] <= '0;
					end
				end
				REQ_MIX: begin
					if (!free) begin
						pos_q[vidx_q] <= pos_q[vidx_q] + ADDR_W'(1);
						rem_q[vidx_q] <= rem_q[vidx_q] - 16'd1;
					end
				end
				REQ_LOAD: begin
				end
			endcase
		end
	end

	pcmmix_ram #(
		.WIDTH (DATA_W),
		.DEPTH (1 << ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (cmd.store_we),
		.waddr (ADDR_W'(laddr_q)),
		.wdata (lbyte_q),
		.raddr (pos_q[vidx_q]),
		.rdata (rd_data)
	);

	assign samp_sx = $signed(ACC_W'(rd_data)) - $signed(ACC_W'(SAMPLE_MID));

	// per-item result accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1     <= 1'b0;
			acc_q      <= $signed(ACC_W'(SAMPLE_MID));
			active_q   <= '0;
			stopped_q  <= '0;
			accepted_q <= 1'b0;
			chan_q     <= '0;
		end else begin
			act_s1 <= cmd.step && (op_q == REQ_MIX) && !free;
			if (cmd.capture) begin
				acc_q      <= $signed(ACC_W'(SAMPLE_MID));
				active_q   <= '0;
				stopped_q  <= '0;
				accepted_q <= 1'b0;
				chan_q     <= '0;
			end else begin
				if (act_s1) begin
					acc_q <= acc_q + samp_sx;
				end
				if (cmd.step) begin
					if (op_q == REQ_MIX && !free) begin
						active_q <= active_q + CNT_W'(1);
					end
					if (op_q == REQ_STOP && snd_q[vidx_q] == id_q) begin
						stopped_q <= stopped_q + CNT_W'(1);
					end
					if (op_q == REQ_PLAY && free) begin
						accepted_q <= 1'b1;
						chan_q     <= vidx_q;
					end
				end
			end
		end
	end

	always_comb begin
		if (op_q != REQ_MIX) begin
			clip = 8'(SAMPLE_MID);
		end else if (acc_q[ACC_W-1]) begin
			clip = 8'd0;
		end else if (acc_q > $signed(ACC_W'(SAMPLE_MAX))) begin
			clip = 8'(SAMPLE_MAX);
		end else begin
			clip = acc_q[7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_data_q <= {4'd0, 4'(stopped_q), 3'(chan_q), accepted_q, 4'(active_q), clip};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_read_only_mix: assert property (@(posedge clk) disable iff (!arst_n)
		act_s1 |-> op_q == REQ_MIX)
		else $error("store read accumulated outside a mix");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vidx_q <= last_idx_q)
		else $error("scan index beyond voices in use");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(out_valid_q && !m_tready))
		else $error("result register overwritten while held");

	a_play_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && op_q == REQ_PLAY && free) |=> !cmd.step)
		else $error("scan continued after play took a voice");
`endif

endmodule

// ----- hdl/multichannel_pcm_mixer_core.sv -----
// Top level of the multichannel PCM mixer: controller, datapath and ports.
//
// Usage
//   Input stream (s_*): one item per request. s_tuser is the request kind
//   (load byte, play, stop, mix tick); s_tdata carries the request fields.
//   Output stream (m_*): exactly one result item for every input item, in
//   order. Non-mix requests return sample_out = 128 and zero counters,
//   except play_accepted/channel_used for play and stopped_count for stop.
//   cfg_we/cfg_data write the voice count (clamped to 2..MAX_VOICES);
//   write only while no request is in flight.
// Steps after the accept edge: load writes the store byte; play scans up
//   to the first free voice; stop and mix scan all voices in use, and mix
//   then drains the last store read. The scan handles one voice per cycle,
//   bounded by the single read port of the sample store.
// Throughput: a new item is taken once the previous result has entered the
//   output register.
// Reset: all voices free with position and sound id zero, voice count 6.
//   The sample store is not cleared; bytes read before being loaded are
//   undefined.
// Back-pressure: a held result stalls only the final step of the next
//   item; s_tready stays high while the block is idle.
module multichannel_pcm_mixer_core
	import pcmmix_pkg::*;
#(
	parameter int MAX_VOICES      = 8,
	parameter int STORE_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sound_id[7:0], sound_start[23:8], sound_len[39:24],
	// load_addr[55:40], load_byte[63:56]
	input  logic [63:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// sample_out[7:0], active_count[11:8], play_accepted[12],
	// channel_used[15:13], stopped_count[19:16], zero fill[23:20]
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	// num_channels[3:0]
	input  logic [3:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;
	req_t req_in;

	assign req_in = req_t'(s_tuser);

	// sequencer: idle, load write, voice scan, read drain, result hand-off
	pcmmix_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_in   (req_in),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// voice registers, sample store, accumulator and output register
	pcmmix_dp #(
		.MAX_VOICES      (MAX_VOICES),
		.STORE_ADDR_BITS (STORE_ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_in   (req_in),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- bench/multichannel_pcm_mixer_core_test.sv -----
// Self-checking testbench for the PCM mixer core: planned request stream, scoreboard, random idling.
`timescale 1ns / 1ps

module multichannel_pcm_mixer_core_test;
	import pcmmix_pkg::*;

	localparam int MAX_VOICES   = 8;
	localparam int PLAN_SIDE    = 0;    // shadow state used while planning stimulus
	localparam int CHECK_SIDE   = 1;    // shadow state advanced on accepted items
	localparam int IDLE_PCT     = 28;
	localparam int QUIET_FROM   = 250;  // item window with no idling on either side
	localparam int QUIET_TO     = 400;
	localparam int DRAIN_CYCLES = 30;
	localparam int RAND_ITEMS   = 580;

	// one request item, fields at their port widths
	typedef struct packed {
		req_t        kind;
		logic [7:0]  sound_id;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] laddr;
		logic [7:0]  lbyte;
	} pcm_req_t;

	typedef struct packed {
		logic [7:0] sample;
		logic [3:0] active;
		logic       accepted;
		logic [2:0] chan;
		logic [3:0] stopped;
	} mix_result_t;

	typedef enum logic [1:0] {
		PLAN_REQ,        // send one request item
		PLAN_CFG_WRITE,  // wait for idle, then write the voice count
		PLAN_SETTLE      // wait for idle, nothing else
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t kind;
		pcm_req_t   req;
		logic [3:0] cfg_value;
	} plan_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // sound_id, sound_start, sound_len, load_addr, load_byte
	logic [1:0]  s_tuser = REQ_LOAD;  // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // sample_out, active_count, play_accepted, channel_used,
	                             // stopped_count, zero fill
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_data = CFG_NCH_RESET;

	// voice state, one copy for planning and one for checking
	logic [15:0] vpos [2][MAX_VOICES];
	logic [15:0] vrem [2][MAX_VOICES];
	logic [7:0]  vsnd [2][MAX_VOICES];
	logic [3:0]  nch_reg [2];
	logic [7:0]  store_img [2][65536];
	bit          store_loaded [65536];  // planning side: bytes already written

	plan_entry_t request_plan [$];
	mix_result_t expected_results [$];
	logic        in_fire = 1'b0;  // input item taken at the last rising edge
	int          items_sent = 0;
	int          results_seen = 0;
	int          planned = 0;
	int          mismatches = 0;

	multichannel_pcm_mixer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] rnd8();
		return 8'($urandom());
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom());
	endfunction

	function automatic pcm_req_t build_req(req_t kind, logic [7:0] id, logic [15:0] start,
		logic [15:0] len, logic [15:0] laddr, logic [7:0] lbyte);
		pcm_req_t r;
		r.kind = kind;
		r.sound_id = id;
		r.start = start;
		r.len = len;
		r.laddr = laddr;
		r.lbyte = lbyte;
		return r;
	endfunction

	// register value clamped to 2..MAX_VOICES
	function automatic int voices_in_use(logic [3:0] raw);
		if (raw < CFG_NCH_MIN)
			return int'(CFG_NCH_MIN);
		if (raw > MAX_VOICES)
			return MAX_VOICES;
		return int'(raw);
	endfunction

	// Advance one copy of the mixer state by one request and return its result item.
	function automatic mix_result_t mixer_step(int side, pcm_req_t r);
		mix_result_t res;
		int n;
		int acc;
		bit found;
		res = '0;
		res.sample = 8'(SAMPLE_MID);
		n = voices_in_use(nch_reg[side]);
		found = 1'b0;
		case (r.kind)
			REQ_LOAD: store_img[side][r.laddr] = r.lbyte;
			REQ_PLAY: begin
				// lowest free voice wins; none free drops the request
				for (int i = 0; i < n; i++) begin
					if (!found && vrem[side][i] == 16'd0) begin
						vpos[side][i] = r.start;
						vrem[side][i] = r.len;
						vsnd[side][i] = r.sound_id;
						res.accepted = 1'b1;
						res.chan = 3'(i);
						found = 1'b1;
					end
				end
			end
			REQ_STOP: begin
				// ids stay after a voice ends, so free voices match too
				for (int i = 0; i < n; i++) begin
					if (vsnd[side][i] == r.sound_id) begin
						vpos[side][i] = '0;
						vrem[side][i] = '0;
						res.stopped = res.stopped + 4'd1;
					end
				end
			end
			default: begin
				acc = SAMPLE_MID;
				for (int i = 0; i < n; i++) begin
					if (vrem[side][i] != 16'd0) begin
						acc = acc + int'(store_img[side][vpos[side][i]]) - SAMPLE_MID;
						res.active = res.active + 4'd1;
						vpos[side][i] = vpos[side][i] + 16'd1;
						vrem[side][i] = vrem[side][i] - 16'd1;
					end
				end
				if (acc < 0)
					acc = 0;
				if (acc > SAMPLE_MAX)
					acc = SAMPLE_MAX;
				res.sample = 8'(acc);
			end
		endcase
		return res;
	endfunction

	task automatic plan_req(pcm_req_t r);
		plan_entry_t e;
		e.kind = PLAN_REQ;
		e.req = r;
		e.cfg_value = '0;
		request_plan.push_back(e);
		void'(mixer_step(PLAN_SIDE, r));
		if (r.kind == REQ_LOAD)
			store_loaded[r.laddr] = 1'b1;
		planned++;
	endtask

	// A mix must never read a byte that was never loaded: load any such byte first.
	task automatic plan_mix();
		int n;
		n = voices_in_use(nch_reg[PLAN_SIDE]);
		for (int i = 0; i < n; i++) begin
			if (vrem[PLAN_SIDE][i] != 16'd0 && !store_loaded[vpos[PLAN_SIDE][i]])
				plan_req(build_req(REQ_LOAD, rnd8(), rnd16(), rnd16(),
					vpos[PLAN_SIDE][i], rnd8()));
		end
		plan_req(build_req(REQ_MIX, rnd8(), rnd16(), rnd16(), rnd16(), rnd8()));
	endtask

	task automatic plan_wait(plan_kind_t kind, logic [3:0] value);
		plan_entry_t e;
		e = '0;
		e.kind = kind;
		e.cfg_value = value;
		request_plan.push_back(e);
		if (kind == PLAN_CFG_WRITE)
			nch_reg[PLAN_SIDE] = value;
	endtask

	function automatic pcm_req_t unpack_req(logic [1:0] user, logic [63:0] data);
		return build_req(req_t'(user), data[7:0], data[23:8], data[39:24], data[55:40],
			data[63:56]);
	endfunction

	task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Driver: presents planned items, holds config writes and pauses until the block is idle.
	always @(negedge clk) begin
		logic next_valid;
		logic next_we;
		bool_quiet: begin end
		next_valid = s_tvalid && !in_fire;
		next_we = 1'b0;
		if (arst_n && !next_valid && request_plan.size() != 0) begin
			if (request_plan[0].kind == PLAN_REQ) begin
				if ((items_sent >= QUIET_FROM && items_sent < QUIET_TO)
					|| $urandom_range(99) >= IDLE_PCT) begin
					s_tdata <= {request_plan[0].req.lbyte, request_plan[0].req.laddr,
						request_plan[0].req.len, request_plan[0].req.start,
						request_plan[0].req.sound_id};
					s_tuser <= request_plan[0].req.kind;
					next_valid = 1'b1;
					items_sent++;
					void'(request_plan.pop_front());
				end
			end else if (!s_tvalid && expected_results.size() == 0) begin
				// every result is back, so the block is idle
				if (request_plan[0].kind == PLAN_CFG_WRITE) begin
					cfg_data <= request_plan[0].cfg_value;
					next_we = 1'b1;
				end
				void'(request_plan.pop_front());
			end
		end
		s_tvalid <= next_valid;
		cfg_we <= next_we;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= (results_seen >= QUIET_FROM && results_seen < QUIET_TO)
				|| $urandom_range(99) >= IDLE_PCT;
	end

	// Monitor: check results in order, predict each accepted item, track config writes.
	always @(posedge clk) begin
		mix_result_t want;
		in_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: result item %h with no request pending", $time, m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					compare_field("sample_out", want.sample, m_tdata[7:0]);
					compare_field("active_count", 8'(want.active), 8'(m_tdata[11:8]));
					compare_field("play_accepted", 8'(want.accepted), 8'(m_tdata[12]));
					compare_field("channel_used", 8'(want.chan), 8'(m_tdata[15:13]));
					compare_field("stopped_count", 8'(want.stopped), 8'(m_tdata[19:16]));
					compare_field("fill bits", 8'd0, 8'(m_tdata[23:20]));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(mixer_step(CHECK_SIDE, unpack_req(s_tuser, s_tdata)));
			if (cfg_we)
				nch_reg[CHECK_SIDE] = cfg_data;
		end
	end

	initial begin : stimulus
		int target;
		int next_cfg_at;
		int phase;
		int pick;
		int region;
		logic [15:0] bases [4];
		logic [3:0] cfg_steps [12];
		logic [15:0] len;
		logic [15:0] start;
		logic [15:0] addr;
		logic [7:0] id;
		logic [7:0] value;

		for (int s = 0; s < 2; s++) begin
			nch_reg[s] = CFG_NCH_RESET;
			for (int i = 0; i < MAX_VOICES; i++) begin
				vpos[s][i] = '0;
				vrem[s][i] = '0;
				vsnd[s][i] = '0;
			end
		end

		// Directed part. Bytes at both ends of the store so a sound wraps around.
		plan_req(build_req(REQ_LOAD, rnd8(), rnd16(), rnd16(), 16'hFFFF, 8'hFF));
		plan_req(build_req(REQ_LOAD, rnd8(), rnd16(), rnd16(), 16'h0000, 8'hFF));
		plan_req(build_req(REQ_LOAD, rnd8(), rnd16(), rnd16(), 16'h0001, 8'h00));
		plan_req(build_req(REQ_PLAY, 8'hFF, 16'hFFFF, 16'd3, rnd16(), rnd8()));
		plan_req(build_req(REQ_PLAY, 8'h00, 16'hFFFF, 16'hFFFF, rnd16(), rnd8()));
		// zero length: accepted, takes the id, voice stays free
		plan_req(build_req(REQ_PLAY, 8'h07, 16'h0000, 16'h0000, rnd16(), rnd8()));
		plan_mix();  // clips high
		plan_mix();  // clips high
		plan_mix();  // clips low
		plan_req(build_req(REQ_STOP, 8'h07, rnd16(), rnd16(), rnd16(), rnd8()));
		// id zero also hits the voices untouched since reset
		plan_req(build_req(REQ_STOP, 8'h00, rnd16(), rnd16(), rnd16(), rnd8()));
		// fill all six voices, the seventh play is dropped
		for (int k = 0; k < 7; k++)
			plan_req(build_req(REQ_PLAY, 8'hA5, 16'h0000, 16'd2, rnd16(), rnd8()));
		// count above the maximum acts as eight voices
		plan_wait(PLAN_CFG_WRITE, 4'd15);
		plan_req(build_req(REQ_PLAY, 8'hA5, 16'h0000, 16'd2, rnd16(), rnd8()));
		plan_req(build_req(REQ_PLAY, 8'hA5, 16'h0000, 16'd2, rnd16(), rnd8()));
		plan_mix();  // all eight voices active
		plan_req(build_req(REQ_STOP, 8'hA5, rnd16(), rnd16(), rnd16(), rnd8()));

		// Random part: sounds live in a few preloaded regions, one near the top of the store.
		bases = '{16'hFFF4, 16'h8000, rnd16(), rnd16()};
		for (int b = 0; b < 4; b++)
			for (int k = 0; k < 24; k++)
				plan_req(build_req(REQ_LOAD, rnd8(), rnd16(), rnd16(), bases[b] + 16'(k), rnd8()));
		cfg_steps = '{4'd2, 4'd0, 4'd8, 4'd1, 4'd9, 4'd3, 4'd15, 4'd5, 4'd7, 4'd4, 4'd12, 4'd6};
		target = planned + RAND_ITEMS;
		next_cfg_at = planned + 60;
		phase = 0;
		while (planned < target) begin
			if (planned >= next_cfg_at) begin
				// voice count changes with voices still playing; hidden ones keep state
				plan_wait(PLAN_CFG_WRITE, cfg_steps[phase]);
				phase = (phase + 1) % 12;
				next_cfg_at = planned + 60;
			end
			pick = $urandom_range(99);
			region = $urandom_range(3);
			if (pick < 45) begin
				plan_mix();
			end else if (pick < 65) begin
				id = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : rnd8();
				start = ($urandom_range(9) == 0) ? rnd16()
					: bases[region] + 16'($urandom_range(15));
				pick = $urandom_range(19);
				if (pick == 0)
					len = 16'h0000;
				else if (pick == 1)
					len = 16'hFFFF;
				else if (pick == 2)
					len = rnd16();
				else
					len = 16'($urandom_range(24, 1));
				plan_req(build_req(REQ_PLAY, id, start, len, rnd16(), rnd8()));
			end else if (pick < 75) begin
				pick = $urandom_range(9);
				if (pick < 5)
					id = vsnd[PLAN_SIDE][$urandom_range(voices_in_use(nch_reg[PLAN_SIDE]) - 1)];
				else if (pick < 9)
					id = 8'($urandom_range(7));
				else
					id = rnd8();
				plan_req(build_req(REQ_STOP, id, rnd16(), rnd16(), rnd16(), rnd8()));
			end else if (pick < 97) begin
				addr = $urandom_range(1) ? bases[region] + 16'($urandom_range(31)) : rnd16();
				pick = $urandom_range(9);
				value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : rnd8();
				plan_req(build_req(REQ_LOAD, rnd8(), rnd16(), rnd16(), addr, value));
			end else begin
				// sender holds off until every result is back
				plan_wait(PLAN_SETTLE, 4'd0);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_plan.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#(5_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
